// File: hw/rtl/hisp_pkg.sv
`timescale 1ns / 1ps

package hisp_pkg;

    // Format codes as they appear on the result channel
    localparam logic [2:0] FMT_UNKNOWN = 3'd0;
    localparam logic [2:0] FMT_JPEG    = 3'd1;
    localparam logic [2:0] FMT_GIF     = 3'd2;
    localparam logic [2:0] FMT_PNG     = 3'd3;
    localparam logic [2:0] FMT_BMP     = 3'd4;

    // Header signature bytes
    localparam logic [7:0] BYTE_FF = 8'hFF;
    localparam logic [7:0] BYTE_D8 = 8'hD8;
    localparam logic [7:0] BYTE_C0 = 8'hC0;
    localparam logic [7:0] BYTE_C1 = 8'hC1;
    localparam logic [7:0] BYTE_89 = 8'h89;
    localparam logic [7:0] CHAR_G  = 8'h47;
    localparam logic [7:0] CHAR_I  = 8'h49;
    localparam logic [7:0] CHAR_F  = 8'h46;
    localparam logic [7:0] CHAR_P  = 8'h50;
    localparam logic [7:0] CHAR_N  = 8'h4E;
    localparam logic [7:0] CHAR_B  = 8'h42;
    localparam logic [7:0] CHAR_M  = 8'h4D;

    // Offsets and lengths of the size fields
    localparam logic [4:0] GIF_START = 5'd6;
    localparam logic [4:0] GIF_COUNT = 5'd4;
    localparam logic [4:0] PNG_START = 5'd16;
    localparam logic [4:0] PNG_COUNT = 5'd8;
    localparam logic [4:0] BMP_START = 5'd18;
    localparam logic [4:0] BMP_COUNT = 5'd8;
    localparam logic [4:0] HDR_LEN   = 5'd4;
    localparam logic [4:0] POS_MAX   = 5'd31;

    // Snapshot of the scan state after the final byte
    typedef struct packed {
        logic [2:0]       fmt;
        logic [3:0][7:0]  frame0;
        logic [3:0][7:0]  frame1;
        logic [7:0][7:0]  lanes;
    } t_scan_res;

    // One result item
    typedef struct packed {
        logic [2:0]         fmt;
        logic signed [31:0] width;
        logic signed [31:0] height;
    } t_result;

    // Classify the (zero-filled) four-byte header
    function automatic logic [2:0] judge_format(input logic [3:0][7:0] h);
        logic [2:0] f;
        f = FMT_UNKNOWN;
        if (h[0] == BYTE_FF && h[1] == BYTE_D8) begin
            f = FMT_JPEG;
        end else if (h[0] == CHAR_G && h[1] == CHAR_I && h[2] == CHAR_F) begin
            f = FMT_GIF;
        end else if (h[0] == BYTE_89 && h[1] == CHAR_P && h[2] == CHAR_N
                     && h[3] == CHAR_G) begin
            f = FMT_PNG;
        end else if (h[0] == CHAR_B && h[1] == CHAR_M) begin
            f = FMT_BMP;
        end
        return f;
    endfunction

endpackage

// File: hw/rtl/hisp_if.sv
`timescale 1ns / 1ps

// Byte stream channel
interface hisp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

// Result channel
interface hisp_out_if;
    logic               valid;
    logic               ready;
    logic [2:0]         image_format;
    logic signed [31:0] image_width;
    logic signed [31:0] image_height;

    modport source (output valid, output image_format, output image_width,
                    output image_height, input ready);
    modport sink   (input valid, input image_format, input image_width,
                    input image_height, output ready);
endinterface

// File: hw/rtl/hisp_scan.sv
`timescale 1ns / 1ps

module hisp_scan (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_accept,
    input  logic [7:0]            i_data_byte,
    input  logic                  i_last_byte,
    output hisp_pkg::t_scan_res   o_res
);
    import hisp_pkg::*;

    // JPEG marker phase codes (low two bits; bit 2 selects the C1 frame)
    localparam logic [1:0] PH_SEEK = 2'd0;
    localparam logic [1:0] PH_CODE = 2'd1;
    localparam logic [1:0] PH_SKIP = 2'd2;
    localparam logic [1:0] PH_READ = 2'd3;

    logic [4:0]       r_pos,    n_pos;
    logic [3:0][7:0]  r_hdr,    n_hdr;
    logic [2:0]       r_fmt,    n_fmt;
    logic [2:0]       r_phase,  n_phase;
    logic [2:0]       r_cnt,    n_cnt;
    logic [7:0][7:0]  r_lanes,  n_lanes;
    logic [3:0][7:0]  r_frame0, n_frame0;
    logic [3:0][7:0]  r_frame1, n_frame1;

    logic       base;
    logic [7:0] code;
    logic [2:0] cnt_inc;
    logic [4:0] start;
    logic [4:0] count;
    logic [4:0] off;

    assign base    = r_phase[2];
    assign code    = base ? BYTE_C1 : BYTE_C0;
    assign cnt_inc = r_cnt + 3'd1;

    // Pick the size-field window of the detected format
    always_comb begin
        start = GIF_START;
        count = 5'd0;
        case (r_fmt)
            FMT_GIF: begin start = GIF_START; count = GIF_COUNT; end
            FMT_PNG: begin start = PNG_START; count = PNG_COUNT; end
            FMT_BMP: begin start = BMP_START; count = BMP_COUNT; end
            default: begin start = GIF_START; count = 5'd0; end
        endcase
    end

    assign off = r_pos - start;

    // Advance the scan by one byte
    always_comb begin
        n_pos    = r_pos;
        n_hdr    = r_hdr;
        n_fmt    = r_fmt;
        n_phase  = r_phase;
        n_cnt    = r_cnt;
        n_lanes  = r_lanes;
        n_frame0 = r_frame0;
        n_frame1 = r_frame1;
        if (i_accept) begin
            if (r_pos < HDR_LEN) begin
                n_hdr[r_pos[1:0]] = i_data_byte;
                n_fmt = judge_format(n_hdr);
            end else if (r_fmt == FMT_JPEG) begin
                unique case (r_phase[1:0])
                    PH_SEEK: begin
                        if (i_data_byte == BYTE_FF) begin
                            n_phase = {base, PH_CODE};
                        end
                    end
                    PH_CODE: begin
                        n_phase = (i_data_byte == code) ? {base, PH_SKIP} : {base, PH_SEEK};
                        n_cnt   = 3'd0;
                    end
                    PH_SKIP: begin
                        if (cnt_inc >= 3'd3) begin
                            n_phase = {base, PH_READ};
                            n_cnt   = 3'd0;
                        end else begin
                            n_cnt = cnt_inc;
                        end
                    end
                    PH_READ: begin
                        if (r_cnt < 3'd4) begin
                            if (base) begin
                                n_frame1[~r_cnt[1:0]] = r_frame1[~r_cnt[1:0]] | i_data_byte;
                            end else begin
                                n_frame0[~r_cnt[1:0]] = r_frame0[~r_cnt[1:0]] | i_data_byte;
                            end
                            n_cnt = cnt_inc;
                            if (cnt_inc == 3'd4 && !base) begin
                                n_phase = {1'b1, PH_SEEK};
                                n_cnt   = 3'd0;
                            end
                        end
                    end
                endcase
            end else if (r_pos >= start && off < count) begin
                n_lanes[off[2:0]] = r_lanes[off[2:0]] | i_data_byte;
            end
            if (r_pos != POS_MAX) begin
                n_pos = r_pos + 5'd1;
            end
        end
    end

    // Hand the post-update state to the result stage
    always_comb begin
        o_res.fmt    = n_fmt;
        o_res.frame0 = n_frame0;
        o_res.frame1 = n_frame1;
        o_res.lanes  = n_lanes;
    end

    // Hold scan state; clear it after the final byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_accept && i_last_byte)) begin
            r_pos    <= '0;
            r_hdr    <= '0;
            r_fmt    <= FMT_UNKNOWN;
            r_phase  <= '0;
            r_cnt    <= '0;
            r_lanes  <= '0;
            r_frame0 <= '0;
            r_frame1 <= '0;
        end else begin
            r_pos    <= n_pos;
            r_hdr    <= n_hdr;
            r_fmt    <= n_fmt;
            r_phase  <= n_phase;
            r_cnt    <= n_cnt;
            r_lanes  <= n_lanes;
            r_frame0 <= n_frame0;
            r_frame1 <= n_frame1;
        end
    end

endmodule

// File: hw/rtl/hisp_out_stage.sv
`timescale 1ns / 1ps

module hisp_out_stage (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  hisp_pkg::t_scan_res  i_res,
    input  logic                 i_full_search,
    output logic                 o_in_ready,
    hisp_out_if.source           o_out
);
    import hisp_pkg::*;

    logic    r_valid;
    logic    r_skid_valid;
    t_result r_data;
    t_result r_skid;
    t_result res;
    logic    pop;

    // Turn the scan snapshot into width and height
    function automatic t_result format_result(input t_scan_res s, input logic fs);
        t_result r;
        r.fmt = s.fmt;
        case (s.fmt)
            FMT_JPEG: begin
                if (fs && {s.frame1[1], s.frame1[0]} != 16'd0
                       && {s.frame1[3], s.frame1[2]} != 16'd0) begin
                    r.width  = {16'd0, s.frame1[1], s.frame1[0]};
                    r.height = {16'd0, s.frame1[3], s.frame1[2]};
                end else begin
                    r.width  = {16'd0, s.frame0[1], s.frame0[0]};
                    r.height = {16'd0, s.frame0[3], s.frame0[2]};
                end
            end
            FMT_GIF: begin
                r.width  = {16'd0, s.lanes[1], s.lanes[0]};
                r.height = {16'd0, s.lanes[3], s.lanes[2]};
            end
            FMT_PNG: begin
                r.width  = {s.lanes[0], s.lanes[1], s.lanes[2], s.lanes[3]};
                r.height = {s.lanes[4], s.lanes[5], s.lanes[6], s.lanes[7]};
            end
            FMT_BMP: begin
                r.width  = {s.lanes[3], s.lanes[2], s.lanes[1], s.lanes[0]};
                r.height = {s.lanes[7], s.lanes[6], s.lanes[5], s.lanes[4]};
            end
            default: begin
                r.width  = '1;
                r.height = '1;
            end
        endcase
        return r;
    endfunction

    assign res        = format_result(i_res, i_full_search);
    assign pop        = r_valid && o_out.ready;
    assign o_in_ready = !r_skid_valid;

    // Drive the result channel from the main register
    assign o_out.valid        = r_valid;
    assign o_out.image_format = r_data.fmt;
    assign o_out.image_width  = r_data.width;
    assign o_out.image_height = r_data.height;

    // Load main or skid register; drain skid into main on a pop
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid      <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (pop) begin
                r_data       <= r_skid;
                r_skid_valid <= 1'b0;
            end
        end else if (i_push) begin
            if (r_valid && !pop) begin
                r_skid       <= res;
                r_skid_valid <= 1'b1;
            end else begin
                r_data  <= res;
                r_valid <= 1'b1;
            end
        end else if (pop) begin
            r_valid <= 1'b0;
        end
    end

endmodule

// File: hw/rtl/image_header_size_parser_core.sv
`timescale 1ns / 1ps

// Image header size parser.
// i_in carries the file one byte per transaction (data_byte, last_byte).
// The first four bytes pick JPEG, GIF, PNG, BMP or unknown; the size
// fields are then picked out of the stream as the bytes go by.
// On the transaction with last_byte set, one result (image_format,
// image_width, image_height) is queued on o_out and the scan state
// clears for the next file.
// Throughput: one byte per cycle while i_in.ready is high.
// The result is valid on o_out in the cycle after the last byte
// is accepted when no earlier result is waiting; otherwise it follows
// as soon as o_out drains the earlier one.
// A main result register plus one skid register sit on the output, so
// i_in keeps accepting while a result waits; only when both hold a
// result does i_in.ready drop until o_out drains one.
// i_cfg_we writes i_cfg_wdata into full_search (write while idle).
// Reset (i_rst_n low, synchronous) clears the scan state, empties the
// output registers and sets full_search to 1.
module image_header_size_parser_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_wdata,
    hisp_in_if.sink     i_in,
    hisp_out_if.source  o_out
);
    import hisp_pkg::*;

    logic      r_full_search;
    logic      accept;
    logic      in_ready;
    t_scan_res scan_res;

    assign i_in.ready = in_ready;
    assign accept     = i_in.valid && in_ready;

    // Hold the configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_full_search <= 1'b1;
        end else if (i_cfg_we) begin
            r_full_search <= i_cfg_wdata;
        end
    end

    hisp_scan u_scan (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_data_byte (i_in.data_byte),
        .i_last_byte (i_in.last_byte),
        .o_res       (scan_res)
    );

    hisp_out_stage u_out_stage (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_push        (accept && i_in.last_byte),
        .i_res         (scan_res),
        .i_full_search (r_full_search),
        .o_in_ready    (in_ready),
        .o_out         (o_out)
    );

endmodule

// File: hw/rtl/hisp_checker.sv
`timescale 1ns / 1ps

module hisp_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic        i_in_last,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [2:0]  i_out_format,
    input logic [31:0] i_out_width,
    input logic [31:0] i_out_height
);

    // Stalled result stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result dropped while stalled");

    // Stalled result payload holds
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            $stable(i_out_format) && $stable(i_out_width) && $stable(i_out_height))
        else $error("result changed while stalled");

    // A new result only follows an accepted final byte
    a_out_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_out_valid) |-> $past(i_in_valid && i_in_ready && i_in_last))
        else $error("result without final byte");

    // Input back-pressure only while a result is pending
    a_ready_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in_ready |-> i_out_valid)
        else $error("input stalled with empty output");

endmodule

bind image_header_size_parser_core hisp_checker u_hisp_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in.valid),
    .i_in_ready   (i_in.ready),
    .i_in_last    (i_in.last_byte),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_out_format (o_out.image_format),
    .i_out_width  (o_out.image_width),
    .i_out_height (o_out.image_height)
);

// File: sim/image_header_size_parser_checker.sv
`timescale 1ns / 1ps

module image_header_size_parser_checker (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_cfg_we,
    input  logic i_cfg_wdata,
    hisp_in_if   i_in_mon,
    hisp_out_if  i_out_mon,
    output int   o_pending,
    output int   o_fail_count,
    output int   o_checked
);
    import hisp_pkg::*;

    // JPEG marker search steps (low two bits); bit 2 selects the FF C1 pass
    localparam logic [1:0] SEEK_FF  = 2'd0;
    localparam logic [1:0] SEEK_SOF = 2'd1;
    localparam logic [1:0] SKIP_HDR = 2'd2;
    localparam logic [1:0] READ_DIM = 2'd3;
    localparam int         SKIP_LEN = 3;
    localparam int         DIM_LEN  = 4;

    // Shadow of the block's scan state
    logic            full_search;
    logic [4:0]      byte_pos;
    logic [3:0][7:0] hdr;
    logic [2:0]      fmt;
    logic [2:0]      phase;
    logic [2:0]      pcount;
    logic [63:0]     lanes;
    logic [31:0]     frame0;
    logic [31:0]     frame1;

    t_result pending_sizes[$];
    t_result got;
    t_result want;
    int      mismatches = 0;
    int      checked = 0;

    task automatic report(input string msg);
        if (mismatches < 100) begin
            $display("MISMATCH at %0t: %s", $time, msg);
        end
        mismatches++;
    endtask

    task automatic clear_scan();
        byte_pos = '0;
        hdr      = '0;
        fmt      = FMT_UNKNOWN;
        phase    = '0;
        pcount   = '0;
        lanes    = '0;
        frame0   = '0;
        frame1   = '0;
    endtask

    // Classify the header; later checks override earlier ones, so JPEG wins
    function automatic logic [2:0] format_of(input logic [3:0][7:0] h);
        logic [2:0] f;
        f = FMT_UNKNOWN;
        if (h[0] == CHAR_B && h[1] == CHAR_M) f = FMT_BMP;
        if (h[0] == BYTE_89 && h[1] == CHAR_P && h[2] == CHAR_N && h[3] == CHAR_G) f = FMT_PNG;
        if (h[0] == CHAR_G && h[1] == CHAR_I && h[2] == CHAR_F) f = FMT_GIF;
        if (h[0] == BYTE_FF && h[1] == BYTE_D8) f = FMT_JPEG;
        return f;
    endfunction

    // Advance the JPEG frame marker search by one byte
    task automatic scan_marker(input logic [7:0] b);
        logic        pass2;
        logic [7:0]  code;
        logic [31:0] v;
        pass2 = phase[2];
        code  = pass2 ? BYTE_C1 : BYTE_C0;
        case (phase[1:0])
            SEEK_FF: begin
                if (b == BYTE_FF) phase = {pass2, SEEK_SOF};
            end
            SEEK_SOF: begin
                phase  = (b == code) ? {pass2, SKIP_HDR} : {pass2, SEEK_FF};
                pcount = '0;
            end
            SKIP_HDR: begin
                pcount++;
                if (pcount >= SKIP_LEN) begin
                    phase  = {pass2, READ_DIM};
                    pcount = '0;
                end
            end
            default: begin
                if (pcount < DIM_LEN) begin
                    v = 32'(b) << (8 * (DIM_LEN - 1 - pcount));
                    if (pass2) frame1 |= v;
                    else frame0 |= v;
                    pcount++;
                    if (pcount == DIM_LEN && !pass2) begin
                        phase  = {1'b1, SEEK_FF};
                        pcount = '0;
                    end
                end
            end
        endcase
    endtask

    // Collect bytes of a fixed-offset size field
    task automatic grab_field(input logic [4:0] pos, input logic [4:0] start,
                              input logic [4:0] count, input logic [7:0] b);
        if (pos >= start && pos - start < count) begin
            lanes |= 64'(b) << (8 * (pos - start));
        end
    endtask

    // Update the shadow state for one byte; queue the size at the last byte
    task automatic scan_byte(input logic [7:0] b, input logic last);
        logic [4:0]  pos;
        logic [31:0] w;
        logic [31:0] h;
        t_result     r;
        pos = byte_pos;
        if (pos < HDR_LEN) begin
            hdr[pos[1:0]] = b;
            fmt = format_of(hdr);
        end else if (fmt == FMT_JPEG) begin
            scan_marker(b);
        end else if (fmt == FMT_GIF) begin
            grab_field(pos, GIF_START, GIF_COUNT, b);
        end else if (fmt == FMT_PNG) begin
            grab_field(pos, PNG_START, PNG_COUNT, b);
        end else if (fmt == FMT_BMP) begin
            grab_field(pos, BMP_START, BMP_COUNT, b);
        end
        if (byte_pos != POS_MAX) byte_pos++;
        if (last) begin
            case (fmt)
                FMT_JPEG: begin
                    w = {16'h0, frame0[15:0]};
                    h = {16'h0, frame0[31:16]};
                    if (full_search && frame1[15:0] != '0 && frame1[31:16] != '0) begin
                        w = {16'h0, frame1[15:0]};
                        h = {16'h0, frame1[31:16]};
                    end
                end
                FMT_GIF: begin
                    w = {16'h0, lanes[15:0]};
                    h = {16'h0, lanes[31:16]};
                end
                FMT_PNG: begin
                    w = {lanes[7:0], lanes[15:8], lanes[23:16], lanes[31:24]};
                    h = {lanes[39:32], lanes[47:40], lanes[55:48], lanes[63:56]};
                end
                FMT_BMP: begin
                    w = lanes[31:0];
                    h = lanes[63:32];
                end
                default: begin
                    w = '1;
                    h = '1;
                end
            endcase
            r.fmt    = fmt;
            r.width  = w;
            r.height = h;
            pending_sizes.push_back(r);
            clear_scan();
        end
    endtask

    // Watch both channels and the register port at every edge
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            full_search = 1'b1;
            clear_scan();
            pending_sizes.delete();
        end else begin
            if (i_in_mon.valid && i_in_mon.ready) begin
                scan_byte(i_in_mon.data_byte, i_in_mon.last_byte);
            end
            if (i_out_mon.valid && i_out_mon.ready) begin
                got.fmt    = i_out_mon.image_format;
                got.width  = i_out_mon.image_width;
                got.height = i_out_mon.image_height;
                if (pending_sizes.size() == 0) begin
                    report($sformatf("result fmt=%0d w=%0d h=%0d with none expected",
                                     got.fmt, got.width, got.height));
                end else begin
                    want = pending_sizes.pop_front();
                    checked++;
                    if (got.fmt !== want.fmt) begin
                        report($sformatf("image_format %0d, expected %0d", got.fmt, want.fmt));
                    end
                    if (got.width !== want.width) begin
                        report($sformatf("image_width %0d, expected %0d",
                                         got.width, want.width));
                    end
                    if (got.height !== want.height) begin
                        report($sformatf("image_height %0d, expected %0d",
                                         got.height, want.height));
                    end
                end
            end
            if (i_cfg_we) full_search = i_cfg_wdata;
        end
        o_pending    <= pending_sizes.size();
        o_fail_count <= mismatches;
        o_checked    <= checked;
    end

endmodule

// File: sim/image_header_size_parser_core_test.sv
`timescale 1ns / 1ps

module image_header_size_parser_core_test;
    import hisp_pkg::*;

    logic i_clk;
    logic i_rst_n;
    logic cfg_we;
    logic cfg_wdata;
    int   pending;
    int   fail_count;
    int   checked;
    int   files_sent = 0;
    int   bytes_sent = 0;
    bit   quiet = 1'b0;

    logic [7:0] file_bytes[$];

    hisp_in_if  in_ch();
    hisp_out_if out_ch();

    image_header_size_parser_core uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .i_in        (in_ch),
        .o_out       (out_ch)
    );

    image_header_size_parser_checker chk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_wdata  (cfg_wdata),
        .i_in_mon     (in_ch),
        .i_out_mon    (out_ch),
        .o_pending    (pending),
        .o_fail_count (fail_count),
        .o_checked    (checked)
    );

    initial i_clk = 1'b0;
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Idle length: mostly none or short, now and then long
    function automatic int pick_gap();
        int r;
        if (quiet) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Random sink stalls on the result channel
    initial begin : drain
        int n;
        out_ch.ready = 1'b0;
        forever begin
            n = pick_gap();
            if (n > 0) begin
                out_ch.ready <= 1'b0;
                repeat (n) @(posedge i_clk);
            end
            out_ch.ready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
    end

    // Push one file byte per transaction, last_byte on the final one
    task automatic send_file();
        int gap;
        foreach (file_bytes[k]) begin
            gap = pick_gap();
            if (gap > 0) begin
                in_ch.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            in_ch.valid     <= 1'b1;
            in_ch.data_byte <= file_bytes[k];
            in_ch.last_byte <= (k == file_bytes.size() - 1);
            @(posedge i_clk);
            while (!in_ch.ready) @(posedge i_clk);
            bytes_sent++;
        end
        files_sent++;
    endtask

    // Drop valid and hold until every result has drained
    task automatic wait_idle();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic set_search(input logic v);
        wait_idle();
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge i_clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic add_random(input int n, input bit no_ff);
        logic [7:0] b;
        repeat (n) begin
            b = 8'($urandom_range(0, 255));
            if (no_ff && b == BYTE_FF) b = 8'hFE;
            file_bytes.push_back(b);
        end
    endtask

    task automatic pad_to(input int len);
        if (file_bytes.size() < len) add_random(len - file_bytes.size(), 1'b0);
    endtask

    task automatic add_word(input logic [31:0] v, input int nbytes, input bit big_end);
        for (int i = 0; i < nbytes; i++) begin
            file_bytes.push_back(big_end ? v[8 * (nbytes - 1 - i) +: 8] : v[8 * i +: 8]);
        end
    endtask

    // Height in the upper half, width in the lower; zero and full scale favored
    function automatic logic [31:0] frame_dims();
        logic [31:0] d;
        d = $urandom;
        case ($urandom_range(0, 7))
            0: d[15:0]  = '0;
            1: d[31:16] = '0;
            2: d        = '1;
            default: ;
        endcase
        return d;
    endfunction

    localparam int SKIP_BYTES = 3;

    // FF marker, three skipped bytes, then height and width
    task automatic add_frame(input logic [7:0] code);
        file_bytes.push_back(BYTE_FF);
        file_bytes.push_back(code);
        add_random(SKIP_BYTES, 1'b0);
        add_word(frame_dims(), 4, 1'b1);
    endtask

    task automatic build_jpeg();
        file_bytes = '{BYTE_FF, BYTE_D8};
        add_random(2, 1'b0);
        if ($urandom_range(0, 9) < 7) begin
            // well-formed frame headers with random filler between
            add_random($urandom_range(0, 4), 1'b1);
            add_frame(BYTE_C0);
            add_random($urandom_range(0, 4), 1'b1);
            if ($urandom_range(0, 2) != 0) begin
                add_frame(BYTE_C1);
                add_random($urandom_range(0, 3), 1'b1);
            end
        end else begin
            repeat ($urandom_range(1, 4)) begin
                case ($urandom_range(0, 6))
                    0: add_random($urandom_range(1, 8), 1'b0);
                    1: add_frame($urandom_range(0, 1) ? BYTE_C1 : BYTE_C0);
                    2: file_bytes = {file_bytes, BYTE_FF, BYTE_FF, BYTE_C0};
                    3: file_bytes = {file_bytes, BYTE_FF, 8'($urandom_range(0, 255))};
                    4: begin
                        file_bytes = {file_bytes, BYTE_FF, BYTE_C0};
                        add_random($urandom_range(0, 5), 1'b0);
                    end
                    5: add_random($urandom_range(10, 30), 1'b1);
                    default: add_frame(8'($urandom_range(BYTE_C0 - 1, BYTE_C1 + 1)));
                endcase
            end
        end
    endtask

    // Unknown headers, near misses of each signature, and very short files
    task automatic build_odd();
        case ($urandom_range(0, 5))
            0: file_bytes = '{BYTE_FF, 8'($urandom_range(0, 255))};
            1: file_bytes = '{CHAR_G, CHAR_I, 8'($urandom_range(0, 255))};
            2: file_bytes = '{BYTE_89, CHAR_P, CHAR_N, 8'($urandom_range(0, 255))};
            3: file_bytes = '{CHAR_B, 8'($urandom_range(0, 255))};
            4: file_bytes = {};
            default: file_bytes = '{8'($urandom_range(0, 255))};
        endcase
        add_random($urandom_range(0, 8), 1'b0);
        if (file_bytes.size() == 0) add_random(1, 1'b0);
    endtask

    initial begin : limit
        #20_000_000;
        $display("Timeout: %0d results still expected", pending);
        $display("Some tests failed");
        $finish;
    end

    initial begin : stimulus
        int r;
        i_rst_n         = 1'b0;
        cfg_we          = 1'b0;
        cfg_wdata       = 1'b0;
        in_ch.valid     = 1'b0;
        in_ch.data_byte = '0;
        in_ch.last_byte = 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // GIF with full-scale width and zero height
        file_bytes = '{CHAR_G, CHAR_I, CHAR_F, 8'h38, 8'h39, 8'h61,
                       8'hFF, 8'hFF, 8'h00, 8'h00};
        send_file();
        // GIF cut short after the signature
        file_bytes = '{CHAR_G, CHAR_I, CHAR_F};
        send_file();
        // PNG with the sign bit alone in width and the largest positive height
        file_bytes = '{BYTE_89, CHAR_P, CHAR_N, CHAR_G};
        pad_to(PNG_START);
        add_word(32'h8000_0000, 4, 1'b1);
        add_word(32'h7FFF_FFFF, 4, 1'b1);
        send_file();
        // BMP with zero width and negative height
        file_bytes = '{CHAR_B, CHAR_M};
        pad_to(BMP_START);
        add_word(32'h0000_0000, 4, 1'b0);
        add_word(32'hFFFF_FFFF, 4, 1'b0);
        send_file();
        // PNG truncated inside the width field
        file_bytes = '{BYTE_89, CHAR_P, CHAR_N, CHAR_G};
        pad_to(PNG_START + 3);
        send_file();
        // FF FF C0 is no marker; the real one follows
        file_bytes = '{BYTE_FF, BYTE_D8, BYTE_FF, 8'hE0, 8'h00, BYTE_FF, BYTE_FF, BYTE_C0,
                       BYTE_FF, BYTE_C0, 8'h00, 8'h11, 8'h08,
                       8'h00, 8'h10, 8'h00, 8'h20};
        send_file();
        // both frame markers with nonzero sizes, then trailing bytes after the second
        file_bytes = '{BYTE_FF, BYTE_D8, 8'h00, 8'h00,
                       BYTE_FF, BYTE_C0, 8'h00, 8'h11, 8'h08, 8'h01, 8'h02, 8'h03, 8'h04,
                       BYTE_FF, BYTE_C1, 8'h00, 8'h11, 8'h08, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
                       BYTE_FF, BYTE_C1, 8'h12, 8'h34};
        send_file();
        // second frame with zero width falls back to the first
        file_bytes = '{BYTE_FF, BYTE_D8, 8'h00, 8'h00,
                       BYTE_FF, BYTE_C0, 8'h00, 8'h11, 8'h08, 8'h00, 8'h40, 8'h00, 8'h30,
                       BYTE_FF, BYTE_C1, 8'h00, 8'h11, 8'h08, 8'h00, 8'h50, 8'h00, 8'h00};
        send_file();
        // JPEG without any frame marker
        file_bytes = '{BYTE_FF, BYTE_D8, BYTE_FF, 8'hE1, 8'h00, 8'h10};
        send_file();
        // unknown header
        file_bytes = '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00};
        send_file();
        // one-byte and two-byte files
        file_bytes = '{BYTE_FF};
        send_file();
        file_bytes = '{BYTE_FF, BYTE_D8};
        send_file();
        file_bytes = '{CHAR_B, CHAR_M};
        send_file();
        // marker well past the saturating byte position
        file_bytes = '{BYTE_FF, BYTE_D8, 8'h00, 8'h00};
        repeat (36) file_bytes.push_back(8'h00);
        file_bytes = {file_bytes, BYTE_FF, BYTE_C0, 8'h00, 8'h00, 8'h00,
                      8'hAB, 8'hCD, 8'h12, 8'h34};
        send_file();

        // second frame size is ignored with full_search cleared
        set_search(1'b0);
        file_bytes = '{BYTE_FF, BYTE_D8, 8'h00, 8'h00,
                       BYTE_FF, BYTE_C0, 8'h00, 8'h11, 8'h08, 8'h01, 8'h02, 8'h03, 8'h04,
                       BYTE_FF, BYTE_C1, 8'h00, 8'h11, 8'h08, 8'h05, 8'h06, 8'h07, 8'h08};
        send_file();

        // random files, with the register flipped now and then
        set_search(1'b1);
        while (bytes_sent < 1850) begin
            if (bytes_sent > 1300 && bytes_sent < 1360) begin
                set_search(1'b0);
            end else if ($urandom_range(0, 24) == 0) begin
                set_search(1'($urandom_range(0, 1)));
            end
            quiet = ($urandom_range(0, 7) == 0);
            r = $urandom_range(0, 99);
            if (r < 35) begin
                build_jpeg();
            end else if (r < 50) begin
                file_bytes = '{CHAR_G, CHAR_I, CHAR_F};
                pad_to($urandom_range(0, 4) != 0 ? $urandom_range(10, 16) : $urandom_range(4, 9));
            end else if (r < 65) begin
                file_bytes = '{BYTE_89, CHAR_P, CHAR_N, CHAR_G};
                pad_to($urandom_range(0, 4) != 0 ? $urandom_range(24, 30) : $urandom_range(5, 23));
            end else if (r < 80) begin
                file_bytes = '{CHAR_B, CHAR_M};
                pad_to($urandom_range(0, 4) != 0 ? $urandom_range(26, 34) : $urandom_range(2, 25));
            end else begin
                build_odd();
            end
            send_file();
        end
        quiet = 1'b0;

        wait_idle();
        repeat (10) @(posedge i_clk);
        $display("Sent %0d files in %0d bytes: JPEG marker scans, GIF/PNG/BMP size fields,",
                 files_sent, bytes_sent);
        $display("short and unknown headers, full_search 0 and 1; %0d results checked",
                 checked);
        if (fail_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
